### hdl/accel_step_counter_unit_assert.svh
// Assertion macros shared by the step counter modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ACCEL_STEP_COUNTER_UNIT_ASSERT_SVH
`define ACCEL_STEP_COUNTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define ASC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASC_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/asc_pkg.sv
package asc_pkg;

    // Field and arithmetic widths.
    localparam int DATA_W     = 16;
    localparam int RADICAND_W = 32;
    localparam int REM_W      = 18;
    localparam int CNT_W      = 4;

    // Step counts of the multi-cycle phases.
    localparam int SQ_STEPS   = 3;
    localparam int ROOT_STEPS = 16;

    // Reset value of the threshold register, milli-g.
    localparam logic [DATA_W-1:0] THR_RESET = 16'd1750;

    // One accelerometer sample.
    typedef struct packed {
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic signed [DATA_W-1:0] accel_z;
        logic                     clear_count;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic [DATA_W-1:0] magnitude;
        logic              step_detected;
        logic [DATA_W-1:0] step_count;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sq_en;
        logic root_en;
        logic sum_en;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic iter_last;
    } dp_status_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SQUARE = 5'b00010,
        ST_ROOT   = 5'b00100,
        ST_SUM    = 5'b01000,
        ST_JUDGE  = 5'b10000
    } state_t;

endpackage

### hdl/asc_ctrl.sv
module asc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  asc_pkg::dp_status_t status,
    output asc_pkg::ctrl_cmd_t  cmd
);

    `include "accel_step_counter_unit_assert.svh"

    asc_pkg::state_t state_reg;
    asc_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // The output register may be refilled when empty or when its item leaves now.
    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            asc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = asc_pkg::ST_SQUARE;
                end
            end
            asc_pkg::ST_SQUARE:
            begin
                if (status.iter_last)
                begin
                    state_next = asc_pkg::ST_ROOT;
                end
            end
            asc_pkg::ST_ROOT:
            begin
                if (status.iter_last)
                begin
                    state_next = asc_pkg::ST_SUM;
                end
            end
            asc_pkg::ST_SUM:
            begin
                state_next = asc_pkg::ST_JUDGE;
            end
            asc_pkg::ST_JUDGE:
            begin
                if (out_free)
                begin
                    state_next = asc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asc_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.load    = (state_reg == asc_pkg::ST_IDLE) && in_valid;
        cmd.sq_en   = (state_reg == asc_pkg::ST_SQUARE);
        cmd.root_en = (state_reg == asc_pkg::ST_ROOT);
        cmd.sum_en  = (state_reg == asc_pkg::ST_SUM);
        cmd.commit  = (state_reg == asc_pkg::ST_JUDGE) && out_free;
    end

    // Output valid flag follows the output register contents.
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != asc_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    // Checks on the sequencing.
    `ASC_ASSERT_IMPLIES(a_commit_free, cmd.commit, !out_valid_reg || !out_stall, "commit into a held output")
    `ASC_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_reg == asc_pkg::ST_SQUARE, "accepted item did not start")
    `ASC_ASSERT_IMPLIES(a_valid_from_commit, $rose(out_valid_reg), $past(cmd.commit), "result appeared without commit")

endmodule

### hdl/asc_dp.sv
module asc_dp
#(
    parameter int WINDOW = 5
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  asc_pkg::in_item_t        in_item,
    input  logic                     cfg_wr_en,
    input  logic [asc_pkg::DATA_W-1:0] cfg_wr_data,
    input  asc_pkg::ctrl_cmd_t       cmd,
    output asc_pkg::dp_status_t      status,
    output asc_pkg::out_item_t       out_item
);

    `include "accel_step_counter_unit_assert.svh"

    localparam int HIST_DEPTH = WINDOW - 1;
    localparam int SUM_W      = $clog2(WINDOW) + asc_pkg::DATA_W;
    localparam int DW         = asc_pkg::DATA_W;
    localparam int RW         = asc_pkg::REM_W;
    localparam int CW         = asc_pkg::CNT_W;

    // Sample registers.
    logic signed [DW-1:0] axis_reg [3];
    logic signed [DW-1:0] axis_next [3];
    logic                 clear_reg;

    // Square accumulator, later shifted out as the root radicand.
    logic [asc_pkg::RADICAND_W-1:0] acc_reg;
    logic [asc_pkg::RADICAND_W-1:0] acc_next;
    logic signed [2*DW-1:0]         prod;

    // Root iteration.
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   rem_next;
    logic [DW-1:0]   root_reg;
    logic [DW-1:0]   root_next;
    logic [RW+1:0]   rem_shift;
    logic [RW+1:0]   trial;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;

    // Window and detection state.
    logic [DW-1:0]    thr_reg;
    logic [DW-1:0]    hist_reg [HIST_DEPTH];
    logic [DW-1:0]    hist_next [HIST_DEPTH];
    logic [SUM_W-1:0] hist_sum_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] thr_scaled_reg;
    logic             was_above_reg;
    logic [DW-1:0]    total_reg;
    logic [DW-1:0]    total_next;
    logic [DW-1:0]    total_base;
    logic             above;
    logic             step;
    asc_pkg::out_item_t out_item_reg;

    // Squaring: one axis per cycle through a single multiplier.
    assign prod = axis_reg[0] * axis_reg[0];

    always_comb
    begin
        axis_next[0] = axis_reg[1];
        axis_next[1] = axis_reg[2];
        axis_next[2] = axis_reg[0];
    end

    // One root digit per cycle: bring down two radicand bits and try the next root bit.
    assign rem_shift = {rem_reg, acc_reg[asc_pkg::RADICAND_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        if (rem_shift >= trial)
        begin
            rem_next  = RW'(rem_shift - trial);
            root_next = {root_reg[DW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = RW'(rem_shift);
            root_next = {root_reg[DW-2:0], 1'b0};
        end
    end

    // Accumulator: cleared on load, summed while squaring, shifted while rooting.
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.load)
        begin
            acc_next = '0;
        end
        else if (cmd.sq_en)
        begin
            acc_next = acc_reg + asc_pkg::RADICAND_W'(unsigned'(prod));
        end
        else if (cmd.root_en)
        begin
            acc_next = {acc_reg[asc_pkg::RADICAND_W-3:0], 2'b00};
        end
    end

    // Step counter for both multi-cycle phases.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = CW'(asc_pkg::SQ_STEPS - 1);
        end
        else if (cmd.sq_en && (cnt_reg == '0))
        begin
            cnt_next = CW'(asc_pkg::ROOT_STEPS - 1);
        end
        else if (cmd.sq_en || cmd.root_en)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    assign status.iter_last = (cnt_reg == '0);

    // Threshold decision and saturating step total.
    assign above = (sum_reg > thr_scaled_reg);
    assign step  = above && !was_above_reg;

    always_comb
    begin
        total_base = clear_reg ? '0 : total_reg;
        total_next = total_base;
        if (step && (total_base != '1))
        begin
            total_next = total_base + DW'(1);
        end
    end

    // New delay line contents with the current magnitude at the front.
    always_comb
    begin
        hist_next[0] = root_reg;
        for (int k = 1; k < HIST_DEPTH; k++)
        begin
            hist_next[k] = hist_reg[k-1];
        end
    end

    // Working registers of one item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.load)
        begin
            axis_reg[0] <= in_item.accel_x;
            axis_reg[1] <= in_item.accel_y;
            axis_reg[2] <= in_item.accel_z;
            clear_reg   <= in_item.clear_count;
            rem_reg     <= '0;
            root_reg    <= '0;
        end
        else if (cmd.sq_en)
        begin
            axis_reg <= axis_next;
        end
        else if (cmd.root_en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.sum_en)
        begin
            sum_reg        <= hist_sum_reg + SUM_W'(root_reg);
            thr_scaled_reg <= SUM_W'(thr_reg) * SUM_W'(WINDOW);
        end
        if (cmd.commit)
        begin
            out_item_reg.magnitude     <= root_reg;
            out_item_reg.step_detected <= step;
            out_item_reg.step_count    <= total_next;
        end
    end

    // State that persists between items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= asc_pkg::THR_RESET;
            hist_sum_reg  <= '0;
            was_above_reg <= 1'b0;
            total_reg     <= '0;
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                hist_sum_reg  <= hist_sum_reg + SUM_W'(root_reg)
                                 - SUM_W'(hist_reg[HIST_DEPTH-1]);
                was_above_reg <= above;
                total_reg     <= total_next;
                hist_reg      <= hist_next;
            end
        end
    end

    assign out_item = out_item_reg;

    // A reported step always leaves a non-zero total.
    `ASC_ASSERT_NEXT(a_step_counts, cmd.commit && step, out_item_reg.step_count != '0, "step without count")

endmodule

### hdl/accel_step_counter_unit.sv
// Step counter for a three-axis accelerometer.
// Input channel: in_valid / in_stall carrying in_item (accel_x, accel_y, accel_z in
// signed milli-g, plus clear_count). An item is taken on a rising edge with in_valid
// high and in_stall low.
// Output channel: out_valid / out_stall carrying out_item (magnitude, step_detected,
// step_count), one result per sample, in order.
// After the edge that accepts the item, it passes through the squaring steps on the
// single multiplier, the digit-by-digit square root, a step forming the window sum
// and scaled threshold, and a step to judge and load the output register, where the
// result is presented.
// One item is worked on at a time and in_stall drops as the result is loaded, so a new
// item is not taken before the last one is done.
// The result sits in an output register, so the next sample may be accepted while it
// waits; if the receiver stalls, the next item holds in its judging step until the
// output register frees up, and in_stall stays high meanwhile.
// cfg_wr_en / cfg_wr_data write the step threshold (milli-g); write it only while idle.
// Reset clears the magnitude history, the crossing flag and the step total, and sets
// the threshold to 1750 milli-g; no clearing pass is needed.
module accel_step_counter_unit
#(
    parameter int WINDOW = 5
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  asc_pkg::in_item_t          in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output asc_pkg::out_item_t         out_item,
    input  logic                       cfg_wr_en,
    input  logic [asc_pkg::DATA_W-1:0] cfg_wr_data
);

    asc_pkg::ctrl_cmd_t  cmd;
    asc_pkg::dp_status_t status;

    // Sequencer.
    asc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and window state.
    asc_dp
    #(
        .WINDOW (WINDOW)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_item    (out_item)
    );

endmodule
